/* hdl/stack_vm_integer_alu_core_macros.svh */
// assertion helpers shared by the alu files
`ifndef STACK_VM_INTEGER_ALU_CORE_MACROS_SVH
`define STACK_VM_INTEGER_ALU_CORE_MACROS_SVH

// condition holds in the same cycle
`define SVM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the cycle after the antecedent
`define SVM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/svm_pkg.sv */
package svm_pkg;

  localparam int XLEN = 64;
  localparam int CW = $clog2(XLEN + 1);

  localparam logic [4:0] ACT_ADD     = 5'd0;
  localparam logic [4:0] ACT_SUB     = 5'd1;
  localparam logic [4:0] ACT_MUL     = 5'd2;
  localparam logic [4:0] ACT_DIV     = 5'd3;
  localparam logic [4:0] ACT_MOD     = 5'd4;
  localparam logic [4:0] ACT_POW     = 5'd5;
  localparam logic [4:0] ACT_SQRT    = 5'd6;
  localparam logic [4:0] ACT_SHL     = 5'd7;
  localparam logic [4:0] ACT_SHR     = 5'd8;
  localparam logic [4:0] ACT_NOT     = 5'd9;
  localparam logic [4:0] ACT_BOOLAND = 5'd10;
  localparam logic [4:0] ACT_BOOLOR  = 5'd11;
  localparam logic [4:0] ACT_NUMEQ   = 5'd12;
  localparam logic [4:0] ACT_NUMNE   = 5'd13;
  localparam logic [4:0] ACT_LT      = 5'd14;
  localparam logic [4:0] ACT_GT      = 5'd15;
  localparam logic [4:0] ACT_LE      = 5'd16;
  localparam logic [4:0] ACT_GE      = 5'd17;
  localparam logic [4:0] ACT_MIN     = 5'd18;
  localparam logic [4:0] ACT_MAX     = 5'd19;
  localparam logic [4:0] ACT_WITHIN  = 5'd20;
  localparam logic [4:0] ACT_SIGN    = 5'd21;
  localparam logic [4:0] ACT_ABS     = 5'd22;
  localparam logic [4:0] ACT_NEGATE  = 5'd23;
  localparam logic [4:0] ACT_INC     = 5'd24;
  localparam logic [4:0] ACT_DEC     = 5'd25;
  localparam logic [4:0] ACT_MODMUL  = 5'd26;
  localparam logic [4:0] ACT_MODPOW  = 5'd27;
  localparam logic [4:0] ACT_NZ      = 5'd28;

  localparam logic [2:0] FAULT_OK    = 3'd0;
  localparam logic [2:0] FAULT_DIV0  = 3'd1;
  localparam logic [2:0] FAULT_EXP   = 3'd2;
  localparam logic [2:0] FAULT_SQRT  = 3'd3;
  localparam logic [2:0] FAULT_SHIFT = 3'd4;
  localparam logic [2:0] FAULT_MOD   = 3'd5;

  typedef struct packed {
    logic [4:0]             action;
    logic signed [XLEN-1:0] operand_a;
    logic signed [XLEN-1:0] operand_b;
    logic signed [XLEN-1:0] operand_c;
  } in_item_t;

  typedef struct packed {
    logic signed [XLEN-1:0] result_value;
    logic [2:0]             fault_code;
  } out_item_t;

  typedef enum logic [1:0] {
    UOP_MUL    = 2'd0,
    UOP_MULMOD = 2'd1,
    UOP_DIV    = 2'd2,
    UOP_SQRT   = 2'd3
  } uop_t;

  typedef struct packed {
    logic start;
    uop_t op;
  } unit_ctl_t;

  function automatic logic [XLEN-1:0] mag(input logic [XLEN-1:0] v);
    return v[XLEN-1] ? (XLEN'(0) - v) : v;
  endfunction

endpackage

/* hdl/svm_serial.sv */
`include "stack_vm_integer_alu_core_macros.svh"

module svm_serial (
  input  logic                     clk,
  input  logic                     rst,
  input  svm_pkg::unit_ctl_t       ctl,
  input  logic [svm_pkg::XLEN-1:0] x,
  input  logic [svm_pkg::XLEN-1:0] y,
  input  logic [svm_pkg::XLEN-1:0] m,
  output logic                     done,
  output logic [svm_pkg::XLEN-1:0] quo,
  output logic [svm_pkg::XLEN-1:0] rem
);
  import svm_pkg::*;

  logic            busy;
  uop_t            op_q;
  logic            phase;
  logic [CW-1:0]   cnt;
  logic [XLEN:0]   acc;
  logic [XLEN-1:0] xr;
  logic [XLEN-1:0] yr;
  logic [XLEN-1:0] mr;
  logic [XLEN-1:0] q;

  logic [XLEN:0]   t;
  logic            t_ge;
  logic [XLEN:0]   t_red;
  logic [XLEN-1:0] mul_sum;
  logic [XLEN-1:0] sq_t;
  logic            sq_ge;
  logic            last;

  always_comb begin
    t = {acc[XLEN-1:0], yr[XLEN-1]};
    case (op_q)
      UOP_MULMOD: begin
        if (!phase) begin
          t = {acc[XLEN-1:0], 1'b0};
        end else begin
          t = acc + {1'b0, (yr[XLEN-1] ? xr : XLEN'(0))};
        end
      end
      default: t = {acc[XLEN-1:0], yr[XLEN-1]};
    endcase
    t_ge = t >= {1'b0, mr};
    t_red = t_ge ? (t - {1'b0, mr}) : t;
    mul_sum = {acc[XLEN-2:0], 1'b0} + (yr[XLEN-1] ? xr : XLEN'(0));
    sq_t = q + mr;
    sq_ge = acc[XLEN-1:0] >= sq_t;
    last = cnt == CW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        op_q <= ctl.op;
        phase <= 1'b0;
        xr <= x;
        yr <= y;
        q <= '0;
        if (ctl.op == UOP_SQRT) begin
          acc <= {1'b0, x};
          mr <= XLEN'(1) << (XLEN - 2);
          cnt <= CW'(XLEN / 2);
        end else begin
          acc <= '0;
          mr <= m;
          cnt <= CW'(XLEN);
        end
      end else if (busy) begin
        case (op_q)
          UOP_MUL: begin
            acc <= {1'b0, mul_sum};
            yr <= yr << 1;
            cnt <= cnt - CW'(1);
            if (last) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
          UOP_MULMOD: begin
            acc <= t_red;
            phase <= !phase;
            if (phase) begin
              yr <= yr << 1;
              cnt <= cnt - CW'(1);
              if (last) begin
                busy <= 1'b0;
                done <= 1'b1;
              end
            end
          end
          UOP_DIV: begin
            acc <= t_red;
            q <= {q[XLEN-2:0], t_ge};
            yr <= yr << 1;
            cnt <= cnt - CW'(1);
            if (last) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
          default: begin
            if (sq_ge) begin
              acc <= {1'b0, acc[XLEN-1:0] - sq_t};
              q <= (q >> 1) + mr;
            end else begin
              q <= q >> 1;
            end
            mr <= mr >> 2;
            cnt <= cnt - CW'(1);
            if (last) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  assign quo = q;
  assign rem = acc[XLEN-1:0];

  `SVM_ASSERT_NOW(a_start_idle, clk, rst, ctl.start, !busy, "start while busy")
  `SVM_ASSERT_NEXT(a_start_busy, clk, rst, ctl.start, busy, "start did not begin work")
  `SVM_ASSERT_NOW(a_done_idle, clk, rst, done, !busy, "done while busy")

endmodule

/* hdl/stack_vm_integer_alu_core.sv */
// integer alu for a stack machine, one instruction at a time
// in channel: in_valid/in_stall carry action and three operands (in_data);
// a transaction is taken at a clock edge with in_valid high and in_stall low
// out channel: out_valid/out_stall carry result_value and fault_code (out_data)
// in_stall is high from acceptance until the result moves to the output register
// with the output register free, compare, logic, add and shift instructions
// go straight to S_DONE, which loads the output register
// mul, div, mod and sqrt run through the shared serial unit, one bit per cycle
// modmul reduces both operands (S_DIVA, S_DIVB), then runs a modular multiply
// (S_MM) that shifts and reduces, then adds and reduces, for each multiplier bit
// pow walks the exponent up to its highest set bit, multiplying for a set bit
// and squaring for every bit; modpow first reduces the base (S_DIVA) and then
// does the same with modular multiplies
// the next transaction is taken in the cycle after out_valid rises at the earliest
// a new instruction is accepted while an earlier result still waits in the
// output register; a stalled result holds until taken
// rst (synchronous) empties the output register and returns to idle
`include "stack_vm_integer_alu_core_macros.svh"

module stack_vm_integer_alu_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  svm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output svm_pkg::out_item_t out_data
);
  import svm_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_MUL  = 10'b0000000010,
    S_DIV  = 10'b0000000100,
    S_SQRT = 10'b0000001000,
    S_DIVA = 10'b0000010000,
    S_DIVB = 10'b0000100000,
    S_MM   = 10'b0001000000,
    S_PMUL = 10'b0010000000,
    S_PSQ  = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  state_t          state;
  state_t          in_next;
  logic            launched;
  logic [4:0]      act_q;
  logic [XLEN-1:0] a_q;
  logic [XLEN-1:0] b_q;
  logic [XLEN-1:0] c_q;
  logic [XLEN-1:0] r_q;
  logic [XLEN-1:0] base_q;
  logic [XLEN-1:0] e_q;
  logic [XLEN-1:0] res_q;
  logic [2:0]      fault_q;

  logic [XLEN-1:0] ia;
  logic [XLEN-1:0] ib;
  logic [XLEN-1:0] ic;
  logic [XLEN-1:0] simple;
  logic [2:0]      in_fault;
  logic            c_bad;

  unit_ctl_t       ctl;
  uop_t            pow_op;
  logic [XLEN-1:0] ux;
  logic [XLEN-1:0] uy;
  logic [XLEN-1:0] um;
  logic            u_done;
  logic [XLEN-1:0] u_quo;
  logic [XLEN-1:0] u_rem;

  svm_serial u_serial (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .x    (ux),
    .y    (uy),
    .m    (um),
    .done (u_done),
    .quo  (u_quo),
    .rem  (u_rem)
  );

  assign ia = in_data.operand_a;
  assign ib = in_data.operand_b;
  assign ic = in_data.operand_c;
  assign c_bad = ic[XLEN-1] || (ic == '0);

  always_comb begin
    simple = '0;
    case (in_data.action)
      ACT_ADD:     simple = ia + ib;
      ACT_SUB:     simple = ia - ib;
      ACT_SHL: begin
        if (ib > XLEN'(XLEN - 1)) begin
          simple = '0;
        end else begin
          simple = ia << ib[$clog2(XLEN)-1:0];
        end
      end
      ACT_SHR: begin
        if (ib > XLEN'(XLEN - 1)) begin
          simple = {XLEN{ia[XLEN-1]}};
        end else begin
          simple = $signed(ia) >>> ib[$clog2(XLEN)-1:0];
        end
      end
      ACT_NOT:     simple = XLEN'(ia == '0);
      ACT_BOOLAND: simple = XLEN'((ia != '0) && (ib != '0));
      ACT_BOOLOR:  simple = XLEN'((ia != '0) || (ib != '0));
      ACT_NUMEQ:   simple = XLEN'(ia == ib);
      ACT_NUMNE:   simple = XLEN'(ia != ib);
      ACT_LT:      simple = XLEN'($signed(ia) < $signed(ib));
      ACT_GT:      simple = XLEN'($signed(ib) < $signed(ia));
      ACT_LE:      simple = XLEN'(!($signed(ib) < $signed(ia)));
      ACT_GE:      simple = XLEN'(!($signed(ia) < $signed(ib)));
      ACT_MIN:     simple = ($signed(ib) < $signed(ia)) ? ib : ia;
      ACT_MAX:     simple = ($signed(ia) < $signed(ib)) ? ib : ia;
      ACT_WITHIN:  simple = XLEN'(!($signed(ia) < $signed(ib)) && ($signed(ia) < $signed(ic)));
      ACT_SIGN: begin
        if (ia[XLEN-1]) begin
          simple = '1;
        end else begin
          simple = XLEN'(ia != '0);
        end
      end
      ACT_ABS:     simple = mag(ia);
      ACT_NEGATE:  simple = XLEN'(0) - ia;
      ACT_INC:     simple = ia + XLEN'(1);
      ACT_DEC:     simple = ia - XLEN'(1);
      ACT_NZ:      simple = XLEN'(ia != '0);
      default:     simple = '0;
    endcase
  end

  always_comb begin
    in_fault = FAULT_OK;
    in_next = S_DONE;
    case (in_data.action)
      ACT_MUL: in_next = S_MUL;
      ACT_DIV, ACT_MOD: begin
        if (ib == '0) begin
          in_fault = FAULT_DIV0;
        end else begin
          in_next = S_DIV;
        end
      end
      ACT_POW: begin
        if (ib[XLEN-1]) begin
          in_fault = FAULT_EXP;
        end else begin
          in_next = S_PMUL;
        end
      end
      ACT_SQRT: begin
        if (ia[XLEN-1]) begin
          in_fault = FAULT_SQRT;
        end else begin
          in_next = S_SQRT;
        end
      end
      ACT_SHL, ACT_SHR: begin
        if (ib[XLEN-1]) begin
          in_fault = FAULT_SHIFT;
        end
      end
      ACT_MODMUL: begin
        if (c_bad) begin
          in_fault = FAULT_MOD;
        end else begin
          in_next = S_DIVA;
        end
      end
      ACT_MODPOW: begin
        if (c_bad) begin
          in_fault = FAULT_MOD;
        end else if (ib[XLEN-1]) begin
          in_fault = FAULT_EXP;
        end else begin
          in_next = S_DIVA;
        end
      end
      default: in_next = S_DONE;
    endcase
  end

  assign pow_op = (act_q == ACT_MODPOW) ? UOP_MULMOD : UOP_MUL;

  always_comb begin
    ctl.start = 1'b0;
    ctl.op = UOP_MUL;
    ux = a_q;
    uy = b_q;
    um = c_q;
    case (state)
      S_MUL: begin
        ctl.start = !launched;
      end
      S_DIV: begin
        ctl.start = !launched;
        ctl.op = UOP_DIV;
        uy = mag(a_q);
        um = mag(b_q);
      end
      S_SQRT: begin
        ctl.start = !launched;
        ctl.op = UOP_SQRT;
      end
      S_DIVA: begin
        ctl.start = !launched;
        ctl.op = UOP_DIV;
        uy = mag(a_q);
      end
      S_DIVB: begin
        ctl.start = !launched;
        ctl.op = UOP_DIV;
        uy = mag(b_q);
      end
      S_MM: begin
        ctl.start = !launched;
        ctl.op = UOP_MULMOD;
        ux = base_q;
        uy = e_q;
      end
      S_PMUL: begin
        ctl.start = !launched && (e_q != '0) && e_q[0];
        ctl.op = pow_op;
        ux = r_q;
        uy = base_q;
      end
      S_PSQ: begin
        ctl.start = !launched;
        ctl.op = pow_op;
        ux = base_q;
        uy = base_q;
      end
      default: ctl.start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      launched <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      if (ctl.start) begin
        launched <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            act_q <= in_data.action;
            a_q <= ia;
            b_q <= ib;
            c_q <= ic;
            r_q <= XLEN'(1);
            base_q <= ia;
            e_q <= ib;
            res_q <= simple;
            fault_q <= in_fault;
            state <= in_next;
          end
        end
        S_MUL: begin
          if (u_done) begin
            res_q <= u_rem;
            launched <= 1'b0;
            state <= S_DONE;
          end
        end
        S_DIV: begin
          if (u_done) begin
            if (act_q == ACT_DIV) begin
              res_q <= (a_q[XLEN-1] != b_q[XLEN-1]) ? (XLEN'(0) - u_quo) : u_quo;
            end else begin
              res_q <= a_q[XLEN-1] ? (XLEN'(0) - u_rem) : u_rem;
            end
            launched <= 1'b0;
            state <= S_DONE;
          end
        end
        S_SQRT: begin
          if (u_done) begin
            res_q <= u_quo;
            launched <= 1'b0;
            state <= S_DONE;
          end
        end
        S_DIVA: begin
          if (u_done) begin
            base_q <= u_rem;
            e_q <= b_q;
            r_q <= (c_q == XLEN'(1)) ? XLEN'(0) : XLEN'(1);
            launched <= 1'b0;
            state <= (act_q == ACT_MODMUL) ? S_DIVB : S_PMUL;
          end
        end
        S_DIVB: begin
          if (u_done) begin
            e_q <= u_rem;
            launched <= 1'b0;
            state <= S_MM;
          end
        end
        S_MM: begin
          if (u_done) begin
            res_q <= (a_q[XLEN-1] != b_q[XLEN-1]) ? (XLEN'(0) - u_rem) : u_rem;
            launched <= 1'b0;
            state <= S_DONE;
          end
        end
        S_PMUL: begin
          if (e_q == '0) begin
            if ((act_q == ACT_MODPOW) && a_q[XLEN-1] && b_q[0]) begin
              res_q <= XLEN'(0) - r_q;
            end else begin
              res_q <= r_q;
            end
            state <= S_DONE;
          end else if (!e_q[0]) begin
            state <= S_PSQ;
          end else if (u_done) begin
            r_q <= u_rem;
            launched <= 1'b0;
            state <= S_PSQ;
          end
        end
        S_PSQ: begin
          if (u_done) begin
            base_q <= u_rem;
            e_q <= e_q >> 1;
            launched <= 1'b0;
            state <= S_PMUL;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            out_data.result_value <= (fault_q != FAULT_OK) ? '0 : res_q;
            out_data.fault_code <= fault_q;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_stall = state != S_IDLE;

  `SVM_ASSERT_NEXT(a_accept_leaves_idle, clk, rst, in_valid && !in_stall, state != S_IDLE, "accepted transaction left block idle")
  `SVM_ASSERT_NOW(a_fault_zero, clk, rst, out_valid && (out_data.fault_code != FAULT_OK), out_data.result_value == '0, "faulted result not zero")
  `SVM_ASSERT_NOW(a_fault_range, clk, rst, out_valid, out_data.fault_code <= FAULT_MOD, "fault code out of range")

endmodule

/* dv/alu_result_checker.sv */
module alu_result_checker
  import svm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        errors,
  output int        pending
);

  out_item_t result_q[$];

  initial begin
    errors = 0;
    pending = 0;
  end

  function automatic logic [63:0] abs_u(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic [63:0] mod_mul(input logic [63:0] x, input logic [63:0] y,
                                          input logic [63:0] m);
    logic [127:0] p;
    p = {64'd0, x} * {64'd0, y};
    return 64'(p % {64'd0, m});
  endfunction

  function automatic out_item_t alu_predict(input in_item_t t);
    logic [63:0] a, b, c, r, e, base, x, root, sq_bit;
    logic [2:0]  f;
    out_item_t   o;
    a = t.operand_a;
    b = t.operand_b;
    c = t.operand_c;
    r = '0;
    f = FAULT_OK;
    case (t.action)
      ACT_ADD: r = a + b;
      ACT_SUB: r = a - b;
      ACT_MUL: r = a * b;
      ACT_DIV, ACT_MOD: begin
        if (b == 0) begin
          f = FAULT_DIV0;
        end else if (t.action == ACT_DIV) begin
          r = abs_u(a) / abs_u(b);
          if (a[63] != b[63]) r = 64'd0 - r;
        end else begin
          r = abs_u(a) % abs_u(b);
          if (a[63]) r = 64'd0 - r;
        end
      end
      ACT_POW: begin
        if (b[63]) begin
          f = FAULT_EXP;
        end else begin
          r = 64'd1;
          e = b;
          base = a;
          while (e != 0) begin
            if (e[0]) r = r * base;
            base = base * base;
            e = e >> 1;
          end
        end
      end
      ACT_SQRT: begin
        if (a[63]) begin
          f = FAULT_SQRT;
        end else begin
          x = a;
          root = 0;
          sq_bit = 64'd1 << 62;
          while (sq_bit > x) sq_bit = sq_bit >> 2;
          while (sq_bit != 0) begin
            if (x >= root + sq_bit) begin
              x = x - (root + sq_bit);
              root = (root >> 1) + sq_bit;
            end else begin
              root = root >> 1;
            end
            sq_bit = sq_bit >> 2;
          end
          r = root;
        end
      end
      ACT_SHL, ACT_SHR: begin
        if (b[63]) f = FAULT_SHIFT;
        else if (b > 63) r = (t.action == ACT_SHR && a[63]) ? '1 : '0;
        else if (t.action == ACT_SHL) r = a << b[5:0];
        else r = $signed(a) >>> b[5:0];
      end
      ACT_NOT:     r = 64'(a == 0);
      ACT_BOOLAND: r = 64'(a != 0 && b != 0);
      ACT_BOOLOR:  r = 64'(a != 0 || b != 0);
      ACT_NUMEQ:   r = 64'(a == b);
      ACT_NUMNE:   r = 64'(a != b);
      ACT_LT:      r = 64'($signed(a) < $signed(b));
      ACT_GT:      r = 64'($signed(a) > $signed(b));
      ACT_LE:      r = 64'($signed(a) <= $signed(b));
      ACT_GE:      r = 64'($signed(a) >= $signed(b));
      ACT_MIN:     r = ($signed(b) < $signed(a)) ? b : a;
      ACT_MAX:     r = ($signed(a) < $signed(b)) ? b : a;
      ACT_WITHIN:  r = 64'($signed(a) >= $signed(b) && $signed(a) < $signed(c));
      ACT_SIGN:    r = a[63] ? '1 : 64'(a != 0);
      ACT_ABS:     r = abs_u(a);
      ACT_NEGATE:  r = 64'd0 - a;
      ACT_INC:     r = a + 1;
      ACT_DEC:     r = a - 1;
      ACT_MODMUL: begin
        if (c[63] || c == 0) begin
          f = FAULT_MOD;
        end else begin
          r = mod_mul(abs_u(a) % c, abs_u(b) % c, c);
          if (a[63] != b[63]) r = 64'd0 - r;
        end
      end
      ACT_MODPOW: begin
        if (c[63] || c == 0) begin
          f = FAULT_MOD;
        end else if (b[63]) begin
          f = FAULT_EXP;
        end else begin
          r = 64'd1 % c;
          e = b;
          base = abs_u(a) % c;
          while (e != 0) begin
            if (e[0]) r = mod_mul(r, base, c);
            base = mod_mul(base, base, c);
            e = e >> 1;
          end
          if (a[63] && b[0]) r = 64'd0 - r;
        end
      end
      ACT_NZ:  r = 64'(a != 0);
      default: r = '0;
    endcase
    o.result_value = (f != FAULT_OK) ? '0 : r;
    o.fault_code = f;
    return o;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst) begin
      if (in_valid && !in_stall) result_q.push_back(alu_predict(in_data));
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $error("unexpected result transaction: value %0d fault %0d",
                 out_data.result_value, out_data.fault_code);
          errors++;
        end else begin
          want = result_q.pop_front();
          if (out_data.result_value !== want.result_value) begin
            $error("result_value: expected %0d, actual %0d",
                   want.result_value, out_data.result_value);
            errors++;
          end
          if (out_data.fault_code !== want.fault_code) begin
            $error("fault_code: expected %0d, actual %0d",
                   want.fault_code, out_data.fault_code);
            errors++;
          end
        end
      end
      pending = result_q.size();
    end
  end

endmodule

/* dv/stack_vm_integer_alu_core_tb.sv */
module stack_vm_integer_alu_core_tb;
  import svm_pkg::*;

  localparam int N_RANDOM = 2000;
  localparam int CYCLE_LIMIT = 3000000;
  localparam logic [63:0] MIN_V = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX_V = 64'h7fff_ffff_ffff_ffff;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  int        errors;
  int        pending;
  int        cycles = 0;
  bit        quiet_in = 1'b0;
  bit        quiet_out = 1'b0;

  always #5 clk = ~clk;

  stack_vm_integer_alu_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  alu_result_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .errors   (errors),
    .pending  (pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 19);
    if (k < 12) return 0;
    if (k < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver back-pressure, with quiet stretches
  always @(negedge clk) begin
    if ($urandom_range(0, 299) == 0) quiet_out = ~quiet_out;
    if (quiet_out) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 9) < 3) || ($urandom_range(0, 49) == 0);
  end

  function automatic logic [63:0] pick_val();
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0: v = 0;
      1: v = 1;
      2: v = '1;
      3: v = MIN_V;
      4: v = MAX_V;
      5: begin
        v = $urandom_range(0, 40);
        v = v - 20;
      end
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic in_item_t mk(input logic [4:0] act, input logic [63:0] a,
                                  input logic [63:0] b, input logic [63:0] c);
    in_item_t t;
    t.action = act;
    t.operand_a = a;
    t.operand_b = b;
    t.operand_c = c;
    return t;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t t;
    t = mk(5'($urandom_range(0, 31)), pick_val(), pick_val(), pick_val());
    if ((t.action == ACT_SHL || t.action == ACT_SHR) && $urandom_range(0, 2) != 0)
      t.operand_b = $urandom_range(0, 70);
    if (t.action == ACT_POW || t.action == ACT_MODPOW) begin
      if ($urandom_range(0, 19) == 0) t.operand_b = {1'b0, 63'({$urandom, $urandom})};
      else if ($urandom_range(0, 9) != 0) t.operand_b = $urandom_range(0, 300);
    end
    if ((t.action == ACT_MODMUL || t.action == ACT_MODPOW) && $urandom_range(0, 9) < 7) begin
      if ($urandom_range(0, 1) != 0) t.operand_c = {1'b0, 63'({$urandom, $urandom})};
      else t.operand_c = $urandom_range(1, 100);
    end
    return t;
  endfunction

  task automatic send(input in_item_t t);
    int g;
    in_data = t;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    g = quiet_in ? 0 : gap_len();
    if (g > 0) begin
      in_valid = 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    in_item_t directed[$];
    repeat (11) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    directed.push_back(mk(ACT_ADD, MAX_V, 1, 0));
    directed.push_back(mk(ACT_SUB, MIN_V, 1, 0));
    directed.push_back(mk(ACT_MUL, MAX_V, MAX_V, 0));
    directed.push_back(mk(ACT_DIV, 5, 0, 0));
    directed.push_back(mk(ACT_DIV, MIN_V, '1, 0));
    directed.push_back(mk(ACT_MOD, MIN_V, '1, 0));
    directed.push_back(mk(ACT_MOD, -64'd7, 3, 0));
    directed.push_back(mk(ACT_POW, 0, 0, 0));
    directed.push_back(mk(ACT_POW, 0, 5, 0));
    directed.push_back(mk(ACT_POW, 3, '1, 0));
    directed.push_back(mk(ACT_POW, -64'd3, 41, 0));
    directed.push_back(mk(ACT_SQRT, MAX_V, 0, 0));
    directed.push_back(mk(ACT_SQRT, '1, 0, 0));
    directed.push_back(mk(ACT_SHL, 1, 64, 0));
    directed.push_back(mk(ACT_SHR, -64'd9, 100, 0));
    directed.push_back(mk(ACT_SHR, -64'd9, 3, 0));
    directed.push_back(mk(ACT_SHL, 1, '1, 0));
    directed.push_back(mk(ACT_ABS, MIN_V, 0, 0));
    directed.push_back(mk(ACT_NEGATE, MIN_V, 0, 0));
    directed.push_back(mk(ACT_MODMUL, MAX_V, MIN_V, MAX_V - 2));
    directed.push_back(mk(ACT_MODMUL, 5, 7, 0));
    directed.push_back(mk(ACT_MODPOW, 2, '1, '1));
    directed.push_back(mk(ACT_MODPOW, 9, 0, 1));
    directed.push_back(mk(ACT_MODPOW, -64'd7, 13, MAX_V));
    directed.push_back(mk(ACT_WITHIN, 5, 5, 6));
    directed.push_back(mk(5'd31, MAX_V, MAX_V, MAX_V));
    foreach (directed[i]) send(directed[i]);
    drain();

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 250 == 0) quiet_in = ($urandom_range(0, 3) == 0);
      if (n == 1000) drain();
      send(rand_item());
    end

    drain();
    repeat (30) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
